FILE: rtl/rrjq_pkg.sv
// shared types, constants and codes of the round-robin job queue
package rrjq_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int TIME_W      = 16;
   localparam int SUM_W       = TIME_W + CNT_W;

   // result field widths and saturation limits
   localparam int TOTAL_W     = 20;
   localparam int COUNT_W     = 5;
   localparam int TOTAL_MAX   = (1 << TOTAL_W) - 1;
   localparam int COUNT_MAX   = (1 << COUNT_W) - 1;

   // configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic REG_QUANTUM = 1'b0;
   localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd1;

   // action codes
   localparam logic [1:0] ACT_ADD     = 2'd0;
   localparam logic [1:0] ACT_SERVICE = 2'd1;
   localparam logic [1:0] ACT_REPORT  = 2'd2;
   localparam logic [1:0] ACT_INVALID = 2'd3;

   // status codes
   localparam logic [2:0] STAT_ADDED     = 3'd0;
   localparam logic [2:0] STAT_REQUEUED  = 3'd1;
   localparam logic [2:0] STAT_FINISHED  = 3'd2;
   localparam logic [2:0] STAT_EMPTY     = 3'd3;
   localparam logic [2:0] STAT_IGNORED   = 3'd4;
   localparam logic [2:0] STAT_INVALID   = 3'd5;

   typedef struct packed {
      logic [1:0]        action;
      logic [TIME_W-1:0] job_time;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [TIME_W-1:0]  run_time;
      logic [TOTAL_W-1:0] total_remaining;
      logic [COUNT_W-1:0] job_count;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/rrjq_ram.sv
// generic single-write, single-read ram with registered read data
module rrjq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rrjq_ctrl.sv
// controller state machine: accept a beat, then execute it once the output slot is free
module rrjq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rrjq_pkg::dp_status_type dp_status,
   output rrjq_pkg::ctrl_cmd_type  cmd
);
   import rrjq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (dp_status.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/rrjq_dp.sv
// datapath: item latch, queue pointers, totals, job store and output register
module rrjq_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  rrjq_pkg::ctrl_cmd_type        cmd,
   output rrjq_pkg::dp_status_type       dp_status,
   input  rrjq_pkg::req_payload_type     req_payload,
   input  logic [rrjq_pkg::TIME_W-1:0]   quantum,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rrjq_pkg::rsp_payload_type     rsp_payload
);
   import rrjq_pkg::*;

   req_payload_type item_ff;
   rsp_payload_type out_ff, out_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;

   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic [TIME_W-1:0] wr_data;
   logic [TIME_W-1:0] job;
   logic [2:0]        status;
   logic [TIME_W-1:0] run;
   logic              empty, full;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   // head entry is fetched while the beat is accepted, used in the execute step
   rrjq_ram #(
      .WIDTH (TIME_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.load),
      .rd_addr (head_ff),
      .rd_data (job)
   );

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      wr_data  = item_ff.job_time;
      run      = '0;
      status   = STAT_INVALID;
      case (item_ff.action)
         ACT_ADD: begin
            if (item_ff.job_time == '0 || full) begin
               status = STAT_IGNORED;
            end else begin
               wr_en    = cmd.exec;
               tail_in  = next_slot(tail_ff);
               count_in = count_ff + CNT_W'(1);
               sum_in   = sum_ff + SUM_W'(item_ff.job_time);
               status   = STAT_ADDED;
            end
         end
         ACT_SERVICE: begin
            if (empty) begin
               status = STAT_EMPTY;
            end else begin
               head_in = next_slot(head_ff);
               if (job > quantum) begin
                  // run one slice and requeue the rest at the back
                  run     = quantum;
                  wr_en   = cmd.exec;
                  wr_data = job - quantum;
                  tail_in = next_slot(tail_ff);
                  sum_in  = sum_ff - SUM_W'(quantum);
                  status  = STAT_REQUEUED;
               end else begin
                  run      = job;
                  count_in = count_ff - CNT_W'(1);
                  sum_in   = sum_ff - SUM_W'(job);
                  status   = STAT_FINISHED;
               end
            end
         end
         ACT_REPORT: begin
            status = empty ? STAT_EMPTY : STAT_ADDED;
         end
         default: begin
            status = STAT_INVALID;
         end
      endcase
   end

   // result beat with saturated totals
   always_comb begin
      out_in.status   = status;
      out_in.run_time = run;
      if (32'(sum_in) > 32'(TOTAL_MAX)) begin
         out_in.total_remaining = TOTAL_W'(TOTAL_MAX);
      end else begin
         out_in.total_remaining = TOTAL_W'(sum_in);
      end
      if (32'(count_in) > 32'(COUNT_MAX)) begin
         out_in.job_count = COUNT_W'(COUNT_MAX);
      end else begin
         out_in.job_count = COUNT_W'(count_in);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign dp_status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.exec) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
            sum_ff   <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_payload;
      end
      if (cmd.exec) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = out_ff;

endmodule

FILE: rtl/round_robin_job_queue.sv
// round-robin job queue top level: csr port, controller and datapath
//
// usage
//   req channel: one beat per command (add, service, report); valid/ready handshake
//   rsp channel: exactly one result beat per request beat, in request order
//   csr port: apb-style, one register (quantum) at byte address 0; pready is tied high
// sequencing
//   a request beat is taken in idle, which latches it and reads the head entry from the
//   job store; once the output slot is free, the execute state runs it against that entry
//   and loads the output register, which drives the result beat; no new beat is taken
//   until that step is done; the separate step is set by the registered job store read port
// stalls
//   the output register holds one result; a new beat may be accepted while it waits,
//   and its execute step holds until the previous result has been taken
// reset
//   synchronous, active high: queue empty, totals zero, quantum back to 1, no result
//   pending; job store contents are not cleared and are never used before written
module round_robin_job_queue (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rrjq_pkg::req_payload_type           req_payload,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rrjq_pkg::rsp_payload_type           rsp_payload,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rrjq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rrjq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rrjq_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import rrjq_pkg::*;

   logic [TIME_W-1:0] quantum_ff;
   logic              csr_write;
   logic              reg_index;
   ctrl_cmd_type      cmd;
   dp_status_type     dp_status;

   // register index is the word address; low two bits are ignored
   assign reg_index  = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
      end else if (csr_write && reg_index == REG_QUANTUM) begin
         quantum_ff <= csr_pwdata[TIME_W-1:0];
      end
   end

   // read back; unmapped word reads zero
   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_QUANTUM) begin
         csr_prdata = CSR_DATA_W'(quantum_ff);
      end
   end

   // sequencing: idle -> execute -> idle
   rrjq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // queue state, job store and result register
   rrjq_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .req_payload (req_payload),
      .quantum     (quantum_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/rrjq_checker.sv
// port-level checks for the round-robin job queue, bound to the top level
module rrjq_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input rrjq_pkg::rsp_payload_type rsp_payload
);
   import rrjq_pkg::*;

   // no result beat right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

   // only a service of a nonempty queue consumes time
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STAT_REQUEUED
         && rsp_payload.status != STAT_FINISHED |-> rsp_payload.run_time == '0)
      else $error("run time reported without a service");

   // empty queue reports no work and no jobs
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STAT_EMPTY
         |-> rsp_payload.job_count == '0 && rsp_payload.total_remaining == '0)
      else $error("empty status with queued work");

   // an added or requeued job is still queued, so the count is nonzero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STAT_REQUEUED || rsp_payload.status == STAT_ADDED)
         |-> rsp_payload.job_count != '0)
      else $error("queue reported empty after add or requeue");

endmodule

bind round_robin_job_queue rrjq_checker u_rrjq_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
